[rtl/core/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

  // operation codes
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // level range, 1 most urgent
  localparam logic [2:0] LEVEL_MIN = 3'd1;
  localparam logic [2:0] LEVEL_MAX = 3'd5;

  localparam int unsigned LEVEL_BITS = 3;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned COUNT_BITS = 5;

  typedef struct packed {
    logic                  cmd;
    logic [LEVEL_BITS-1:0] new_level;
    logic [WORD_BITS-1:0]  new_payload;
  } in_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [LEVEL_BITS-1:0] head_level;
    logic [WORD_BITS-1:0]  head_payload;
    logic [COUNT_BITS-1:0] entry_count;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic insert;
    logic remove;
    logic rep_full;
    logic rep_empty;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_deq;
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

[rtl/core/spq_ctrl.sv]
// ----------------------------------------------------------------------------
// spq_ctrl
// controller: takes an item, then issues one queue operation for it
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  spq_pkg::dp_stat_t  stat_i,
  output spq_pkg::ctrl_cmd_t cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.is_deq) begin
          cmd_o.rep_empty = stat_i.empty;
          cmd_o.remove    = !stat_i.empty;
        end else begin
          cmd_o.rep_full = stat_i.full;
          cmd_o.insert   = !stat_i.full;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q == S_EXEC);

endmodule

[rtl/core/spq_datapath.sv]
// ----------------------------------------------------------------------------
// spq_datapath
// sorted shift-register cells with parallel compare, count and result register
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spq_pkg::in_t       item_i,
  input  spq_pkg::ctrl_cmd_t cmd_i,
  output spq_pkg::dp_stat_t  stat_o,
  output logic               done_o,
  output spq_pkg::out_t      result_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                              deq_q;
  logic [spq_pkg::LEVEL_BITS-1:0]    lvl_q;
  logic [PAYLOAD_BITS-1:0]           pay_q;
  logic [CW-1:0]                     count_q, count_d;
  logic [spq_pkg::LEVEL_BITS-1:0]    level_q [DEPTH];
  logic [PAYLOAD_BITS-1:0]           payload_q [DEPTH];
  logic [DEPTH-1:0]                  ins_ge, first;
  logic [spq_pkg::LEVEL_BITS-1:0]    lvl_sat;
  logic                              done_q;
  spq_pkg::out_t                     out_q;

  // level saturation on capture
  always_comb begin
    lvl_sat = item_i.new_level;
    if (item_i.new_level < spq_pkg::LEVEL_MIN) begin
      lvl_sat = spq_pkg::LEVEL_MIN;
    end else if (item_i.new_level > spq_pkg::LEVEL_MAX) begin
      lvl_sat = spq_pkg::LEVEL_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      deq_q <= (item_i.cmd == spq_pkg::CMD_DEQ);
      lvl_q <= lvl_sat;
      pay_q <= PAYLOAD_BITS'(item_i.new_payload);
    end
  end

  // thermometer of cells at or after the insertion point
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      ins_ge[k] = (count_q <= CW'(k)) || (level_q[k] >= lvl_q);
    end
    first[0] = ins_ge[0];
    for (int k = 1; k < DEPTH; k++) begin
      first[k] = ins_ge[k] && !ins_ge[k-1];
    end
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    always_ff @(posedge clk_i) begin
      if (cmd_i.insert) begin
        if (first[k]) begin
          level_q[k]   <= lvl_q;
          payload_q[k] <= pay_q;
        end else if (ins_ge[k]) begin
          if (k > 0) begin
            level_q[k]   <= level_q[(k > 0) ? k - 1 : 0];
            payload_q[k] <= payload_q[(k > 0) ? k - 1 : 0];
          end
        end
      end else if (cmd_i.remove) begin
        if (k < DEPTH - 1) begin
          level_q[k]   <= level_q[(k < DEPTH - 1) ? k + 1 : k];
          payload_q[k] <= payload_q[(k < DEPTH - 1) ? k + 1 : k];
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.remove) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= cmd_i.insert | cmd_i.remove | cmd_i.rep_full | cmd_i.rep_empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.insert | cmd_i.remove | cmd_i.rep_full | cmd_i.rep_empty) begin
      out_q.status       <= cmd_i.rep_full  ? spq_pkg::ST_FULL :
                            cmd_i.rep_empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_DONE;
      out_q.head_level   <= cmd_i.remove ? level_q[0] : '0;
      out_q.head_payload <= cmd_i.remove ? spq_pkg::WORD_BITS'(payload_q[0]) : '0;
      out_q.entry_count  <= spq_pkg::COUNT_BITS'(count_d);
    end
  end

  assign stat_o.is_deq = deq_q;
  assign stat_o.full   = (count_q >= CW'(DEPTH));
  assign stat_o.empty  = (count_q == '0);
  assign done_o        = done_q;
  assign result_o      = out_q;

endmodule

[rtl/core/sorted_priority_queue_top.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue_top
// bounded priority queue kept sorted by level, 1 most urgent
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low; it is either an
// enqueue (level and payload) or a dequeue of the head. an enqueue goes in
// front of the first held entry of equal or larger level, so newcomers pass
// entries of the same level; a dequeue returns the head. every item gives
// exactly one result, shown on result_o for one cycle with done_o high, after
// the execute state and then the result register. the receiver cannot stall:
// a result must be captured in the cycle it is shown. busy is high for the one
// cycle in which the shift-register cells compare and move, taking no item;
// the next item can be taken in the same cycle its predecessor's
// result is shown. a full queue rejects an enqueue (status full) and an empty
// queue flags a dequeue (status empty), both leaving the contents as they were.
// entry_count is the count after the item, kept to its low five bits.
// ----------------------------------------------------------------------------
module sorted_priority_queue_top #(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::in_t  item_i,
  output logic          done_o,
  output spq_pkg::out_t result_o
);

  spq_pkg::ctrl_cmd_t cmd;
  spq_pkg::dp_stat_t  stat;

  // sequencer: idle, then one execute state per item
  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // cells, count and result register
  spq_datapath #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule
